// ===== rtl/core/ebgs_pkg.sv =====
// ----------------------------------------------------------------------------
// ebgs_pkg
// Shared widths and latencies for the boundary ghost-state pipeline.
// ----------------------------------------------------------------------------
package ebgs_pkg;

    localparam int FRAC_BITS  = 16;

    // restoring divider: 65-bit numerator, 32-bit divisor, 62 quotient bits
    localparam int DIV_NW     = 65;
    localparam int DIV_DW     = 32;
    localparam int DIV_QBITS  = 62;
    localparam int DIV_LAT    = DIV_QBITS + 1;

    // square root: 64-bit radicand, 32-bit root
    localparam int SQ_XW      = 64;
    localparam int SQ_RW      = SQ_XW / 2;
    localparam int SQ_LAT     = SQ_RW + 1;

endpackage

// ===== rtl/core/euler_boundary_ghost_state.sv =====
// ----------------------------------------------------------------------------
// euler_boundary_ghost_state
// Classifies one Euler boundary face per cycle from its characteristic
// speeds and produces the ghost state (wall mirror, outlet, inlet, subsonic).
// ----------------------------------------------------------------------------
//  channel    direction  contents
//  s_axis     in         face state: density, momenta, energy, normal; tuser wall
//  m_axis     out        ghost state: density, momenta, energy; tuser kind
//  i_cfg_*    in         register writes: gamma and far-field state
//
//  one face enters per cycle while the output is not stalled; two chained
//  63-stage dividers (normal velocity / kinetic energy in parallel, then sound
//  speed squared) and a 33-stage square root set the depth
//  the whole pipeline advances together; a stalled output holds every stage
//  synchronous active-low reset clears valid bits and loads default configuration
// ----------------------------------------------------------------------------
module euler_boundary_ghost_state (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // density[30:0] momentum_x[62:31] momentum_y[94:63] total_energy[125:95]
    // normal_x[141:126] normal_y[157:142], zero fill
    input  logic [159:0] s_axis_tdata,
    // wall_flag[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ghost_density[30:0] ghost_momentum_x[62:31] ghost_momentum_y[94:63]
    // ghost_energy[125:95], zero fill
    output logic [127:0] m_axis_tdata,
    // boundary_kind[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    localparam int L1 = ebgs_pkg::DIV_LAT;
    localparam int LS = ebgs_pkg::SQ_LAT;
    localparam int F  = ebgs_pkg::FRAC_BITS;
    localparam logic [17:0] GAMMA_ONE = 18'(1 << F);
    localparam logic [30:0] ULIM      = '1;

    typedef enum logic [2:0] {
        KIND_SOLID       = 3'd0,
        KIND_OUTLET      = 3'd1,
        KIND_INLET       = 3'd2,
        KIND_SUBSONIC    = 3'd3,
        KIND_BAD_DENSITY = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_GAMMA      = 3'd0,
        CFG_FAR_DENS   = 3'd1,
        CFG_FAR_MX     = 3'd2,
        CFG_FAR_MY     = 3'd3,
        CFG_FAR_ENERGY = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] rho;
        logic [31:0] mx;
        logic [31:0] my;
        logic [30:0] en;
        logic        solid;
        logic        tneg;
        logic [31:0] gwx;
        logic [31:0] gwy;
    } t_side1;

    typedef struct packed {
        t_side1      base;
        logic [31:0] u;
    } t_side2;

    function automatic logic [31:0] umag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -49'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // ---------------- configuration
    logic [17:0] r_gamma;
    logic [30:0] r_far_dens;
    logic [31:0] r_far_mx;
    logic [31:0] r_far_my;
    logic [30:0] r_far_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma    <= 18'd91750;
            r_far_dens <= 31'd65536;
            r_far_mx   <= '0;
            r_far_my   <= '0;
            r_far_en   <= 31'd163840;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAMMA:      r_gamma    <= i_cfg_data[17:0];
                CFG_FAR_DENS:   r_far_dens <= i_cfg_data[30:0];
                CFG_FAR_MX:     r_far_mx   <= i_cfg_data;
                CFG_FAR_MY:     r_far_my   <= i_cfg_data;
                CFG_FAR_ENERGY: r_far_en   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_ov;
    logic [L1-1:0] r_vd1, r_vd2;
    logic [LS-1:0] r_vd3;

    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---------------- stage 1: products
    logic signed [31:0] w_mx, w_my;
    logic signed [15:0] w_nx, w_ny;
    logic [31:0]        w_umx, w_umy;

    assign w_mx  = s_axis_tdata[62:31];
    assign w_my  = s_axis_tdata[94:63];
    assign w_nx  = s_axis_tdata[141:126];
    assign w_ny  = s_axis_tdata[157:142];
    assign w_umx = umag(w_mx);
    assign w_umy = umag(w_my);

    logic [30:0]        r1_rho, r1_en;
    logic signed [31:0] r1_mx, r1_my;
    logic signed [15:0] r1_nx, r1_ny;
    logic               r1_solid;
    logic signed [47:0] r1_pnx, r1_pny;
    logic [63:0]        r1_sqx, r1_sqy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rho   <= s_axis_tdata[30:0];
            r1_mx    <= w_mx;
            r1_my    <= w_my;
            r1_en    <= s_axis_tdata[125:95];
            r1_nx    <= w_nx;
            r1_ny    <= w_ny;
            r1_solid <= s_axis_tuser[0];
            r1_pnx   <= w_mx * w_nx;
            r1_pny   <= w_my * w_ny;
            r1_sqx   <= w_umx * w_umx;
            r1_sqy   <= w_umy * w_umy;
        end
    end

    // ---------------- stage 2: normal momentum, momentum square sum
    logic signed [48:0] w_dsum;
    assign w_dsum = {r1_pnx[47], r1_pnx} + {r1_pny[47], r1_pny};

    logic [30:0]        r2_rho, r2_en;
    logic signed [31:0] r2_mx, r2_my, r2_t;
    logic signed [15:0] r2_nx, r2_ny;
    logic               r2_solid;
    logic [63:0]        r2_ksum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rho   <= r1_rho;
            r2_en    <= r1_en;
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;
            r2_nx    <= r1_nx;
            r2_ny    <= r1_ny;
            r2_solid <= r1_solid;
            r2_t     <= sat32(w_dsum >>> 14);
            r2_ksum  <= r1_sqx + r1_sqy;
        end
    end

    // ---------------- stage 3: wall reflection products
    logic [30:0]        r3_rho, r3_en;
    logic signed [31:0] r3_mx, r3_my, r3_t;
    logic               r3_solid;
    logic [63:0]        r3_ksum;
    logic signed [47:0] r3_pwx, r3_pwy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rho   <= r2_rho;
            r3_en    <= r2_en;
            r3_mx    <= r2_mx;
            r3_my    <= r2_my;
            r3_t     <= r2_t;
            r3_solid <= r2_solid;
            r3_ksum  <= r2_ksum;
            r3_pwx   <= r2_nx * r2_t;
            r3_pwy   <= r2_ny * r2_t;
        end
    end

    // ---------------- stage 4: reflected momentum
    logic signed [48:0] w_pwx_e, w_pwy_e, w_mx_e, w_my_e;
    assign w_pwx_e = {r3_pwx[47], r3_pwx};
    assign w_pwy_e = {r3_pwy[47], r3_pwy};
    assign w_mx_e  = {{17{r3_mx[31]}}, r3_mx};
    assign w_my_e  = {{17{r3_my[31]}}, r3_my};

    t_side1      r4_side;
    logic [31:0] r4_tmag;
    logic [63:0] r4_ksum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side.rho   <= r3_rho;
            r4_side.mx    <= r3_mx;
            r4_side.my    <= r3_my;
            r4_side.en    <= r3_en;
            r4_side.solid <= r3_solid;
            r4_side.tneg  <= r3_t[31];
            r4_side.gwx   <= sat32(w_mx_e - (w_pwx_e >>> 13));
            r4_side.gwy   <= sat32(w_my_e - (w_pwy_e >>> 13));
            r4_tmag       <= umag(r3_t);
            r4_ksum       <= r3_ksum;
        end
    end

    // ---------------- dividers: normal velocity and kinetic energy
    logic [ebgs_pkg::DIV_QBITS-1:0] w_quo_u, w_quo_k, w_quo_c;
    logic                           w_ovf_u, w_ovf_k, w_ovf_c;

    ebgs_div u_div_vel (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({17'd0, r4_tmag, 16'd0}),
        .i_den ({1'b0, r4_side.rho}),
        .o_quo (w_quo_u),
        .o_ovf (w_ovf_u)
    );

    ebgs_div u_div_ke (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({1'b0, r4_ksum}),
        .i_den ({r4_side.rho, 1'b0}),
        .o_quo (w_quo_k),
        .o_ovf (w_ovf_k)
    );

    t_side1 r_d1 [0:L1-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1[0] <= r4_side;
            for (int k = 1; k < L1; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // ---------------- stage 5: signed velocity, pressure product
    logic [30:0] w_um, w_ke, w_diff;
    logic [31:0] w_um32;
    logic [17:0] w_gm1;
    t_side1      w_s1;

    assign w_s1   = r_d1[L1-1];
    assign w_um   = (w_ovf_u || (|w_quo_u[61:31])) ? ULIM : w_quo_u[30:0];
    assign w_ke   = (w_ovf_k || (|w_quo_k[61:31])) ? ULIM : w_quo_k[30:0];
    assign w_um32 = {1'b0, w_um};
    assign w_gm1  = (r_gamma > GAMMA_ONE) ? 18'(r_gamma - GAMMA_ONE) : 18'd0;
    assign w_diff = (w_s1.en > w_ke) ? 31'(w_s1.en - w_ke) : 31'd0;

    t_side2      r5_side;
    logic [48:0] r5_pp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side.base <= w_s1;
            r5_side.u    <= w_s1.tneg ? 32'(~w_um32 + 32'd1) : w_um32;
            r5_pp        <= w_diff * w_gm1;
        end
    end

    // ---------------- stage 6: pressure, gamma * pressure
    logic [30:0] w_p;
    assign w_p = (|r5_pp[48:47]) ? ULIM : r5_pp[46:16];

    t_side2      r6_side;
    logic [48:0] r6_a;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_side <= r5_side;
            r6_a    <= r_gamma * w_p;
        end
    end

    // ---------------- divider: sound speed squared
    ebgs_div u_div_c2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r6_a, 16'd0}),
        .i_den ({1'b0, r6_side.base.rho}),
        .o_quo (w_quo_c),
        .o_ovf (w_ovf_c)
    );

    t_side2 r_d2 [0:L1-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2[0] <= r6_side;
            for (int k = 1; k < L1; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // anything at or above 2^62 saturates the sound speed anyway
    logic [62:0] w_c2;
    assign w_c2 = w_ovf_c ? {1'b1, 62'd0} : {1'b0, w_quo_c};

    logic [ebgs_pkg::SQ_RW-1:0] w_root;

    ebgs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    ({1'b0, w_c2}),
        .o_root (w_root)
    );

    t_side2 r_d3 [0:LS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d3[0] <= r_d2[L1-1];
            for (int k = 1; k < LS; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
        end
    end

    // ---------------- output stage: classification
    t_side2             w_s3;
    logic [30:0]        w_c;
    logic signed [32:0] w_u33, w_c33, w_ev4;
    logic               w_neg1, w_neg2, w_neg4;

    assign w_s3   = r_d3[LS-1];
    assign w_c    = w_root[31] ? ULIM : w_root[30:0];
    assign w_u33  = {w_s3.u[31], w_s3.u};
    assign w_c33  = {2'b00, w_c};
    assign w_ev4  = w_u33 + w_c33;
    assign w_neg1 = w_u33 < w_c33;
    assign w_neg2 = w_s3.u[31];
    assign w_neg4 = w_ev4[32];

    t_kind       n_kind;
    logic [30:0] n_gd, n_ge;
    logic [31:0] n_gx, n_gy;

    always_comb begin
        n_gd   = '0;
        n_gx   = '0;
        n_gy   = '0;
        n_ge   = '0;
        n_kind = KIND_SUBSONIC;
        if (w_s3.base.solid) begin
            n_gd   = w_s3.base.rho;
            n_gx   = w_s3.base.gwx;
            n_gy   = w_s3.base.gwy;
            n_ge   = w_s3.base.en;
            n_kind = KIND_SOLID;
        end else if (w_s3.base.rho == 31'd0) begin
            n_kind = KIND_BAD_DENSITY;
        end else if (!w_neg1 && !w_neg2 && !w_neg4) begin
            n_gd   = w_s3.base.rho;
            n_gx   = w_s3.base.mx;
            n_gy   = w_s3.base.my;
            n_ge   = w_s3.base.en;
            n_kind = KIND_OUTLET;
        end else if (w_neg1 && w_neg2 && w_neg4) begin
            n_gd   = r_far_dens;
            n_gx   = r_far_mx;
            n_gy   = r_far_my;
            n_ge   = r_far_en;
            n_kind = KIND_INLET;
        end
    end

    logic [127:0] r_out_data;
    t_kind        r_out_kind;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {2'b00, n_ge, n_gy, n_gx, n_gd};
            r_out_kind <= n_kind;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_vd1 <= '0;
            r_vd2 <= '0;
            r_vd3 <= '0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_v1  <= s_axis_tvalid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_vd1 <= {r_vd1[L1-2:0], r_v4};
            r_v5  <= r_vd1[L1-1];
            r_v6  <= r_v5;
            r_vd2 <= {r_vd2[L1-2:0], r_v6};
            r_vd3 <= {r_vd3[LS-2:0], r_vd2[L1-1]};
            r_ov  <= r_vd3[LS-1];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

`ifndef SYNTHESIS
    a_inlet_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_INLET) |->
            (m_axis_tdata[30:0] == r_far_dens && m_axis_tdata[125:95] == r_far_en))
        else $error("inlet ghost state differs from far-field registers");

    a_zero_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_SUBSONIC ||
                           m_axis_tuser == KIND_BAD_DENSITY)) |->
            (m_axis_tdata == '0))
        else $error("subsonic or bad-density face with nonzero ghost state");

    a_bad_density: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_OUTLET) |->
            (m_axis_tdata[30:0] != 31'd0))
        else $error("outlet classified with zero density");
`endif

endmodule

// ===== rtl/core/ebgs_div.sv =====
// ----------------------------------------------------------------------------
// ebgs_div
// Pipelined restoring divider, one quotient bit per stage, flags quotients
// that do not fit in the quotient width.
// ----------------------------------------------------------------------------
module ebgs_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ebgs_pkg::DIV_NW-1:0]    i_num,
    input  logic [ebgs_pkg::DIV_DW-1:0]    i_den,
    output logic [ebgs_pkg::DIV_QBITS-1:0] o_quo,
    output logic                           o_ovf
);
    localparam int QB = ebgs_pkg::DIV_QBITS;
    localparam int NW = ebgs_pkg::DIV_NW;
    localparam int DW = ebgs_pkg::DIV_DW;

    logic [NW-1:0] r_num [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [DW-1:0] r_rem [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic          r_ovf [0:QB];

    // top bits of the numerator start the remainder; if they already reach
    // the divisor the quotient is too wide
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_rem[0] <= DW'(i_num[NW-1:QB]);
            r_ovf[0] <= DW'(i_num[NW-1:QB]) >= i_den;
            r_quo[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QB; k++) begin : g_stage
            logic [DW:0] w_sh;
            logic        w_ge;
            assign w_sh = {r_rem[k-1], r_num[k-1][QB-k]};
            assign w_ge = w_sh >= {1'b0, r_den[k-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= r_num[k-1];
                    r_den[k] <= r_den[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                    r_rem[k] <= w_ge ? DW'(w_sh - {1'b0, r_den[k-1]}) : w_sh[DW-1:0];
                    r_quo[k] <= {r_quo[k-1][QB-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];

endmodule

// ===== rtl/core/ebgs_sqrt.sv =====
// ----------------------------------------------------------------------------
// ebgs_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module ebgs_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ebgs_pkg::SQ_XW-1:0]   i_x,
    output logic [ebgs_pkg::SQ_RW-1:0]   o_root
);
    localparam int XW = ebgs_pkg::SQ_XW;
    localparam int RW = ebgs_pkg::SQ_RW;

    logic [XW-1:0] r_x    [0:RW];
    logic [RW:0]   r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_x;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= RW; k++) begin : g_stage
            logic [RW+2:0] w_sh;
            logic [RW+2:0] w_trial;
            logic          w_ge;
            // bring down the next pair of radicand bits
            assign w_sh    = {r_rem[k-1], r_x[k-1][2*(RW-k)+1 -: 2]};
            assign w_trial = {1'b0, r_root[k-1], 2'b01};
            assign w_ge    = w_sh >= w_trial;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]    <= r_x[k-1];
                    r_rem[k]  <= w_ge ? (RW+1)'(w_sh - w_trial) : w_sh[RW:0];
                    r_root[k] <= {r_root[k-1][RW-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW];

endmodule
